>>> rtl/core/bmm_pkg.sv
package bmm_pkg;

	// Field widths
	localparam int OP_W    = 3;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int KIND_W  = 3;
	localparam int MODE_W  = 4;
	localparam int BEAT_W  = 2;

	// Window geometry: sixteen 4 KB windows
	localparam int NUM_WINDOWS = 16;
	localparam int WIN_W       = $clog2(NUM_WINDOWS);
	localparam int OFF_W       = ADDR_W - WIN_W;

	// Operation codes
	localparam logic [OP_W-1:0] OP_MEM_RD  = 3'd0;
	localparam logic [OP_W-1:0] OP_MEM_WR  = 3'd1;
	localparam logic [OP_W-1:0] OP_REG_WR  = 3'd2;
	localparam logic [OP_W-1:0] OP_REG_RD  = 3'd3;
	localparam logic [OP_W-1:0] OP_SET_MODE = 3'd4;

	// Access kinds reported per result
	localparam logic [KIND_W-1:0] K_RAM_RD = 3'd0;
	localparam logic [KIND_W-1:0] K_RAM_WR = 3'd1;
	localparam logic [KIND_W-1:0] K_ROM_RD = 3'd2;
	localparam logic [KIND_W-1:0] K_UNMAP  = 3'd3;
	localparam logic [KIND_W-1:0] K_REG_RD = 3'd4;
	localparam logic [KIND_W-1:0] K_NONE   = 3'd5;

	// Block register values
	localparam logic [DATA_W-1:0] BLK_RESET  = 8'hFF;
	localparam logic [DATA_W-1:0] RAM_LO     = 8'hE0;
	localparam logic [DATA_W-1:0] RAM_HI     = 8'hEF;
	localparam logic [DATA_W-1:0] ROM_LO     = 8'hF8;
	localparam logic [DATA_W-1:0] VID_RED_A  = 8'hE6;
	localparam logic [DATA_W-1:0] VID_RED_B  = 8'hE7;
	localparam logic [DATA_W-1:0] VID_GRN_A  = 8'hEA;
	localparam logic [DATA_W-1:0] VID_GRN_B  = 8'hEB;
	localparam logic [DATA_W-1:0] VID_BLU_A  = 8'hEE;
	localparam logic [DATA_W-1:0] VID_BLU_B  = 8'hEF;

	// Video plane bases
	localparam logic [ADDR_W-1:0] RED_BASE  = 16'h6000;
	localparam logic [ADDR_W-1:0] GRN_BASE  = 16'hA000;
	localparam logic [ADDR_W-1:0] BLU_BASE  = 16'hE000;

	// Write mode bits: bits 0 to 2 enable the planes, MODE_COPY selects copy mode
	localparam int MODE_COPY = 3;

	// Beat index of the final copy-mode write
	localparam logic [BEAT_W-1:0] BEAT_LAST = 2'd2;

	typedef struct packed {
		logic                tbl_we;
		logic                mode_we;
		logic [WIN_W-1:0]    index;
		logic [DATA_W-1:0]   value;
	} regs_wr_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ADDR_W-1:0]   phys;
		logic [DATA_W-1:0]   wdata;
		logic [DATA_W-1:0]   rdata;
		logic                last;
	} map_res_t;

	// Plane base for copy-mode beat: red, green, blue
	function automatic logic [ADDR_W-1:0] plane_base(input logic [BEAT_W-1:0] beat);
		logic [ADDR_W-1:0] base;
		case (beat)
			2'd0:    base = RED_BASE;
			2'd1:    base = GRN_BASE;
			default: base = BLU_BASE;
		endcase
		return base;
	endfunction

endpackage

>>> rtl/core/bmm_req_if.sv
interface bmm_req_if import bmm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [ADDR_W-1:0] address;
	logic [WIN_W-1:0]  block_index;
	logic [DATA_W-1:0] data_in;

	modport source (output valid, operation, address, block_index, data_in, input ready);
	modport sink   (input valid, operation, address, block_index, data_in, output ready);
endinterface

>>> rtl/core/bmm_rsp_if.sv
interface bmm_rsp_if import bmm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] access_kind;
	logic [ADDR_W-1:0] phys_address;
	logic [DATA_W-1:0] write_data;
	logic [DATA_W-1:0] read_data;
	logic              last;

	modport source (output valid, access_kind, phys_address, write_data, read_data, last,
		input ready);
	modport sink   (input valid, access_kind, phys_address, write_data, read_data, last,
		output ready);
endinterface

>>> rtl/core/banked_memory_mapper_with_video_planes.sv
// Banked memory mapper with video planes. Maps a 16-bit CPU address through sixteen 4 KB
// windows, each steered by an 8-bit block register (reset 0xFF), and reports the physical
// access on the result channel; it stores no memory itself. An accepted request is held in
// one input stage, mapped by combinational logic against the block registers and write mode,
// and placed in an output register. Most requests give one result and the block accepts a
// new request every cycle while results are taken; a video write in copy mode gives three
// RAM writes (red, green, blue), during which the input stage holds the request. Block
// register and write mode updates take effect for every later request.
module banked_memory_mapper_with_video_planes import bmm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bmm_req_if.sink      req,
	bmm_rsp_if.source    rsp
);

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [WIN_W-1:0]  bidx_s1;
	logic [DATA_W-1:0] data_s1;
	logic [BEAT_W-1:0] beat_q;

	logic              rsp_valid_q;
	map_res_t          rsp_q;

	logic [WIN_W-1:0]  rd_index;
	logic [DATA_W-1:0] blk_value;
	logic [MODE_W-1:0] mode;
	map_res_t          res;
	regs_wr_t          cmd;
	regs_wr_t          wr;
	logic              load;
	logic              emit;
	logic              done;

	// Select the block register: window for memory ops, index for register ops
	assign rd_index = (op_s1 == OP_REG_RD || op_s1 == OP_REG_WR) ? bidx_s1
		: addr_s1[ADDR_W-1:OFF_W];

	bmm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_index (rd_index),
		.rd_value (blk_value),
		.mode     (mode)
	);

	bmm_map u_map (
		.op        (op_s1),
		.addr      (addr_s1),
		.bidx      (bidx_s1),
		.data      (data_s1),
		.blk_value (blk_value),
		.mode      (mode),
		.beat      (beat_q),
		.res       (res),
		.cmd       (cmd)
	);

	// Handshake: emit a beat when the output register is free or being drained
	assign load      = !rsp_valid_q || rsp.ready;
	assign emit      = valid_s1 && load;
	assign done      = emit && res.last;
	assign req.ready = !valid_s1 || done;

	// Commit register updates as the transaction retires
	always_comb begin
		wr         = cmd;
		wr.tbl_we  = cmd.tbl_we && done;
		wr.mode_we = cmd.mode_we && done;
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_q   <= '0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				beat_q <= '0;
			end else if (emit) begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.operation;
			addr_s1 <= req.address;
			bidx_s1 <= req.block_index;
			data_s1 <= req.data_in;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.access_kind  = rsp_q.kind;
	assign rsp.phys_address = rsp_q.phys;
	assign rsp.write_data   = rsp_q.wdata;
	assign rsp.read_data    = rsp_q.rdata;
	assign rsp.last         = rsp_q.last;

endmodule

>>> rtl/core/bmm_regs.sv
module bmm_regs import bmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  regs_wr_t          wr,
	input  logic [WIN_W-1:0]  rd_index,
	output logic [DATA_W-1:0] rd_value,
	output logic [MODE_W-1:0] mode
);

	logic [DATA_W-1:0] blk_q [NUM_WINDOWS];
	logic [MODE_W-1:0] mode_q;

	// Update block registers and write mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WINDOWS; i++) begin
				blk_q[i] <= BLK_RESET;
			end
			mode_q <= '0;
		end else begin
			if (wr.tbl_we) begin
				blk_q[wr.index] <= wr.value;
			end
			if (wr.mode_we) begin
				mode_q <= wr.value[MODE_W-1:0];
			end
		end
	end

	assign rd_value = blk_q[rd_index];
	assign mode     = mode_q;

endmodule

>>> rtl/core/bmm_map.sv
module bmm_map import bmm_pkg::*; (
	input  logic [OP_W-1:0]   op,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIN_W-1:0]  bidx,
	input  logic [DATA_W-1:0] data,
	input  logic [DATA_W-1:0] blk_value,
	input  logic [MODE_W-1:0] mode,
	input  logic [BEAT_W-1:0] beat,
	output map_res_t          res,
	output regs_wr_t          cmd
);

	logic              is_ram;
	logic              is_rom;
	logic              is_video;
	logic [OFF_W-1:0]  off;
	logic [ADDR_W-1:0] page_addr;
	logic [ADDR_W-1:0] half_off;

	// Classify the selected block register
	always_comb begin
		is_ram   = blk_value inside {[RAM_LO:RAM_HI]};
		is_rom   = blk_value >= ROM_LO;
		is_video = blk_value inside {VID_RED_A, VID_RED_B, VID_GRN_A, VID_GRN_B,
			VID_BLU_A, VID_BLU_B};
		off       = addr[OFF_W-1:0];
		page_addr = {blk_value[WIN_W-1:0], off};
		half_off  = {{(WIN_W-1){1'b0}}, blk_value[0], off};
	end

	// Build the result for the current beat and the register update
	always_comb begin
		res        = '0;
		res.kind   = K_NONE;
		res.last   = 1'b1;
		cmd        = '0;
		cmd.index  = bidx;
		cmd.value  = data;
		case (op)
			OP_MEM_RD: begin
				if (is_ram) begin
					res.kind = K_RAM_RD;
					res.phys = page_addr;
				end else if (is_rom) begin
					// ROM pages start at block value low nibble 8
					res.kind = K_ROM_RD;
					res.phys = {1'b0, blk_value[WIN_W-2:0], off};
				end else begin
					res.kind = K_UNMAP;
				end
			end
			OP_MEM_WR: begin
				if (!is_ram) begin
					res.kind = K_UNMAP;
				end else if (is_video && mode[MODE_COPY]) begin
					// Copy mode: one write per plane, red then green then blue
					res.kind  = K_RAM_WR;
					res.phys  = plane_base(beat) + half_off;
					res.wdata = mode[beat] ? data : '0;
					res.last  = (beat == BEAT_LAST);
				end else begin
					res.kind  = K_RAM_WR;
					res.phys  = page_addr;
					res.wdata = data;
				end
			end
			OP_REG_WR: begin
				cmd.tbl_we = 1'b1;
			end
			OP_REG_RD: begin
				res.kind  = K_REG_RD;
				res.rdata = blk_value;
			end
			OP_SET_MODE: begin
				cmd.mode_we = 1'b1;
			end
			default: begin
				res.kind = K_NONE;
			end
		endcase
	end

endmodule

>>> rtl/core/bmm_checker.sv
module bmm_checker import bmm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [KIND_W-1:0] rsp_kind,
	input logic [ADDR_W-1:0] rsp_phys,
	input logic [DATA_W-1:0] rsp_wdata,
	input logic              rsp_last
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_phys))
		else $error("stalled result changed");

	// Only copy-mode plane writes span several results
	a_multi_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_kind == K_RAM_WR)
		else $error("non-final result is not a RAM write");

	// Follow a taken non-final beat with the next plane write at once
	a_next_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_kind == K_RAM_WR)
		else $error("copy-mode sequence broken");

	// Drop write data and address on readback and no-access results
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == K_REG_RD || rsp_kind == K_NONE || rsp_kind == K_UNMAP)
		|-> rsp_phys == '0 && rsp_wdata == '0)
		else $error("stray address or data on non-memory result");

endmodule

bind banked_memory_mapper_with_video_planes bmm_checker u_bmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.access_kind),
	.rsp_phys  (rsp.phys_address),
	.rsp_wdata (rsp.write_data),
	.rsp_last  (rsp.last)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench import bmm_pkg::*; ();

	// Operation codes the block leaves undefined
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_ITEMS  = 285;
	localparam int HOLD_CYCLES   = 80;
	localparam int HOLD_AT       = 120;
	localparam int DRAIN_CYCLES  = 20;
	localparam int STALL_LIMIT   = 2000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] address;
		logic [WIN_W-1:0]  index;
		logic [DATA_W-1:0] data;
	} cpu_req_t;

	// Mirror of the block registers and write mode, with the accesses still owed
	class access_scoreboard;
		logic [DATA_W-1:0] block_regs [NUM_WINDOWS];
		logic [MODE_W-1:0] wmode;
		map_res_t          pending_accesses [$];
		int                errors;
		int                n_requests;
		int                n_results;
		int                n_plane_copies;

		function new();
			foreach (block_regs[i])
				block_regs[i] = BLK_RESET;
			wmode = '0;
			errors = 0;
			n_requests = 0;
			n_results = 0;
			n_plane_copies = 0;
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		function void owe(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] phys,
			logic [DATA_W-1:0] wd, logic [DATA_W-1:0] rd, logic lst);
			map_res_t e;
			e.kind  = kind;
			e.phys  = phys;
			e.wdata = wd;
			e.rdata = rd;
			e.last  = lst;
			pending_accesses.push_back(e);
		endfunction

		// Start of the video plane a register value writes into, zero if none
		function logic [ADDR_W-1:0] plane_start(logic [DATA_W-1:0] v);
			case (v)
				VID_RED_A, VID_RED_B: return RED_BASE;
				VID_GRN_A, VID_GRN_B: return GRN_BASE;
				VID_BLU_A, VID_BLU_B: return BLU_BASE;
				default:              return '0;
			endcase
		endfunction

		// Map one accepted request to the physical accesses it causes
		function void note_request(cpu_req_t r);
			logic [DATA_W-1:0] v;
			logic [OFF_W-1:0]  off;
			logic [ADDR_W-1:0] base;
			logic [ADDR_W-1:0] half;
			logic              is_ram;
			logic              is_rom;
			v      = block_regs[r.address[ADDR_W-1:OFF_W]];
			off    = r.address[OFF_W-1:0];
			is_ram = (v >= RAM_LO) && (v <= RAM_HI);
			is_rom = (v >= ROM_LO);
			n_requests++;
			case (r.op)
				OP_MEM_RD: begin
					if (is_ram)
						owe(K_RAM_RD, {v[3:0], off}, '0, '0, 1'b1);
					else if (is_rom)
						owe(K_ROM_RD, {v[3:0] - 4'd8, off}, '0, '0, 1'b1);
					else
						owe(K_UNMAP, '0, '0, '0, 1'b1);
				end
				OP_MEM_WR: begin
					base = plane_start(v);
					half = v[0] ? 16'h1000 : 16'h0000;
					if (!is_ram) begin
						owe(K_UNMAP, '0, '0, '0, 1'b1);
					end else if (base == '0) begin
						owe(K_RAM_WR, {v[3:0], off}, r.data, '0, 1'b1);
					end else if (wmode[MODE_COPY]) begin
						// copy mode: red, green, blue in turn
						owe(K_RAM_WR, RED_BASE + off + half, wmode[0] ? r.data : '0, '0, 1'b0);
						owe(K_RAM_WR, GRN_BASE + off + half, wmode[1] ? r.data : '0, '0, 1'b0);
						owe(K_RAM_WR, BLU_BASE + off + half, wmode[2] ? r.data : '0, '0, 1'b1);
						n_plane_copies++;
					end else begin
						owe(K_RAM_WR, base + off + half, r.data, '0, 1'b1);
					end
				end
				OP_REG_WR: begin
					block_regs[r.index] = r.data;
					owe(K_NONE, '0, '0, '0, 1'b1);
				end
				OP_REG_RD: owe(K_REG_RD, '0, '0, block_regs[r.index], 1'b1);
				OP_SET_MODE: begin
					wmode = r.data[MODE_W-1:0];
					owe(K_NONE, '0, '0, '0, 1'b1);
				end
				default: owe(K_NONE, '0, '0, '0, 1'b1);
			endcase
		endfunction

		// Compare one delivered access against the oldest one owed
		task check_access(map_res_t got);
			map_res_t want;
			n_results++;
			if (pending_accesses.size() == 0) begin
				report($sformatf("unexpected result kind %0d phys %h", got.kind, got.phys));
			end else begin
				want = pending_accesses.pop_front();
				if (got.kind !== want.kind)
					report($sformatf("access_kind %0d, expected %0d", got.kind, want.kind));
				if (got.phys !== want.phys)
					report($sformatf("phys_address %h, expected %h", got.phys, want.phys));
				if (got.wdata !== want.wdata)
					report($sformatf("write_data %h, expected %h", got.wdata, want.wdata));
				if (got.rdata !== want.rdata)
					report($sformatf("read_data %h, expected %h", got.rdata, want.rdata));
				if (got.last !== want.last)
					report($sformatf("last %b, expected %b", got.last, want.last));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic calm;

	bmm_req_if req_ch();
	bmm_rsp_if rsp_ch();

	access_scoreboard sb;

	banked_memory_mapper_with_video_planes i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Drive every input to a known value at time zero
	initial begin
		sb = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= '0;
		req_ch.address <= '0;
		req_ch.block_index <= '0;
		req_ch.data_in <= '0;
		rsp_ch.ready <= 1'b0;
	end

	// Offer one transaction, idling first at random, and hold it until accepted
	task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
		input logic [WIN_W-1:0] idx, input logic [DATA_W-1:0] data);
		cpu_req_t r;
		while (!calm && $urandom_range(0, 99) < 33) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.address <= addr;
		req_ch.block_index <= idx;
		req_ch.data_in <= data;
		@(posedge clk);
		while (!(req_ch.valid && req_ch.ready))
			@(posedge clk);
		r.op = op;
		r.address = addr;
		r.index = idx;
		r.data = data;
		sb.note_request(r);
	endtask

	// Pick a register value: mostly video and other RAM pages, then ROM, then anything
	function automatic logic [DATA_W-1:0] pick_block_value();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: begin
				case ($urandom_range(0, 5))
					0:       return VID_RED_A;
					1:       return VID_RED_B;
					2:       return VID_GRN_A;
					3:       return VID_GRN_B;
					4:       return VID_BLU_A;
					default: return VID_BLU_B;
				endcase
			end
			4, 5:    return RAM_LO + DATA_W'($urandom_range(0, 15));
			6, 7:    return ROM_LO + DATA_W'($urandom_range(0, 7));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Random request with a weighted operation mix
	task automatic send_random();
		int                w;
		logic [ADDR_W-1:0] addr;
		logic [WIN_W-1:0]  idx;
		logic [DATA_W-1:0] data;
		w    = $urandom_range(0, 99);
		addr = ADDR_W'($urandom);
		idx  = WIN_W'($urandom);
		data = DATA_W'($urandom);
		if (w < 20)
			send_request(OP_REG_WR, addr, idx, pick_block_value());
		else if (w < 55)
			send_request(OP_MEM_WR, addr, idx, data);
		else if (w < 80)
			send_request(OP_MEM_RD, addr, idx, data);
		else if (w < 88)
			send_request(OP_REG_RD, addr, idx, data);
		else if (w < 95)
			send_request(OP_SET_MODE, addr, idx, data);
		else
			send_request(OP_LAST_UNUSED - OP_W'($urandom_range(0, 2)), addr, idx, data);
	endtask

	// Result side: check accepted transactions, stall at random, hold off once
	initial begin : result_side
		int hold_left;
		int seen;
		bit held;
		map_res_t got;
		hold_left = 0;
		seen = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.kind  = rsp_ch.access_kind;
				got.phys  = rsp_ch.phys_address;
				got.wdata = rsp_ch.write_data;
				got.rdata = rsp_ch.read_data;
				got.last  = rsp_ch.last;
				sb.check_access(got);
				seen++;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (!held && seen >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Main sequence
	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Windows at reset are ROM page 7
		send_request(OP_MEM_RD, 16'h0000, 4'h0, 8'h00);
		send_request(OP_MEM_WR, 16'hFFFF, 4'hF, 8'hFF);
		send_request(OP_REG_RD, 16'h0000, 4'hF, 8'h00);
		// Plain RAM page 0 at window 0
		send_request(OP_REG_WR, 16'h0000, 4'h0, RAM_LO);
		send_request(OP_MEM_RD, 16'h0000, 4'h0, 8'h00);
		send_request(OP_MEM_WR, 16'h0FFF, 4'h0, 8'hFF);
		// Unmapped window: read and write both report unmapped
		send_request(OP_REG_WR, 16'h0000, 4'h1, 8'h10);
		send_request(OP_MEM_RD, 16'h1ABC, 4'h0, 8'h00);
		send_request(OP_MEM_WR, 16'h1000, 4'h0, 8'h77);
		// ROM page 0, read then write
		send_request(OP_REG_WR, 16'h0000, 4'h2, ROM_LO);
		send_request(OP_MEM_RD, 16'h2FFF, 4'h0, 8'h00);
		send_request(OP_MEM_WR, 16'h2123, 4'h0, 8'h55);
		// Red plane first half, single write, then copy to all planes
		send_request(OP_REG_WR, 16'h0000, 4'hF, VID_RED_A);
		send_request(OP_MEM_WR, 16'hF123, 4'h0, 8'hA5);
		send_request(OP_SET_MODE, 16'h0000, 4'h0, 8'h0F);
		send_request(OP_MEM_WR, 16'hF000, 4'h0, 8'h5A);
		// Blue second half, copy with green only enabled
		send_request(OP_REG_WR, 16'h0000, 4'hE, VID_BLU_B);
		send_request(OP_SET_MODE, 16'h0000, 4'h0, 8'hFA);
		send_request(OP_MEM_WR, 16'hEFFF, 4'h0, 8'hFF);
		send_request(OP_MEM_RD, 16'hE456, 4'h0, 8'h00);
		// Back to single plane writes: high bits of the mode byte drop
		send_request(OP_SET_MODE, 16'h0000, 4'h0, 8'hF0);
		send_request(OP_MEM_WR, 16'hE001, 4'h0, 8'h3C);
		send_request(OP_REG_RD, 16'h0000, 4'hE, 8'h00);
		// Undefined operations
		send_request(OP_FIRST_UNUSED, 16'h0000, 4'h0, 8'h00);
		send_request(OP_LAST_UNUSED, 16'hFFFF, 4'hF, 8'hFF);

		// Random part with a stretch of back-to-back traffic in the middle
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 180 && n < 240);
			send_random();
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// Drain what is still owed, then watch for strays
		while (sb.pending_accesses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_accesses.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_accesses.size()));

		$display("Run covered %0d requests and %0d reported accesses", sb.n_requests,
			sb.n_results);
		$display("including %0d copy-mode writes over three planes and one long output stall",
			sb.n_plane_copies);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bmm_pkg.sv
rtl/core/bmm_req_if.sv
rtl/core/bmm_rsp_if.sv
rtl/core/bmm_regs.sv
rtl/core/bmm_map.sv
rtl/core/banked_memory_mapper_with_video_planes.sv
rtl/core/bmm_checker.sv
tb/testbench.sv
